// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of the local minimum detector.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is held.
`define GLMD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("glmd assertion failed");

// Concurrent assertion that also checks during reset.
`define GLMD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("glmd assertion failed");

`endif

// ----- hdl/glmd_pkg.sv -----
// Types and constants of the grid local minimum detector.
// No dependencies; imported by every module of the block but glmd_ram.
package glmd_pkg;

    localparam int HEIGHT_W    = 4;
    localparam int FIELD7_W    = 7;
    localparam int SUM_W       = 18;
    localparam int CFG_W       = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    localparam logic [SUM_W-1:0]    SUM_MAX    = 18'h3FFFF;
    localparam logic [FIELD7_W-1:0] FIELD7_MAX = 7'd127;
    localparam logic [CFG_W-1:0]    WIDTH_RST  = 8'd128;

    localparam logic ACT_CELL  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic                is_minimum;
        logic [HEIGHT_W-1:0] cell_height;
        logic [FIELD7_W-1:0] cell_column;
        logic [FIELD7_W-1:0] cell_row;
        logic [SUM_W-1:0]    risk_sum;
    } t_result;

endpackage

// ----- hdl/glmd_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module glmd_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [W-1:0]             o_rdata_a,
    output logic [W-1:0]             o_rdata_b
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata_a;
    logic [W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- hdl/glmd_core.sv -----
// Cell state, neighbour compares and risk sum of the local minimum detector.
// Depends on glmd_pkg; drives the line store held in glmd_ram.
module glmd_core #(
    parameter int MAX_WIDTH = 128,
    parameter int MAX_ROWS  = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [glmd_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_accept,
    input  logic                          i_action,
    input  logic [glmd_pkg::HEIGHT_W-1:0] i_height,
    output logic                          o_res_valid,
    output glmd_pkg::t_result             o_res,
    output logic                          o_ram_we,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_ram_waddr,
    output logic [7:0]                    o_ram_wdata,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_ram_raddr_a,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_ram_raddr_b,
    input  logic [7:0]                    i_ram_rdata_a,
    input  logic [7:0]                    i_ram_rdata_b
);
    import glmd_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int MW  = (CW > RW) ? CW : RW;
    localparam int XW  = ((MW > CFG_W) ? MW : CFG_W) + 2;

    logic [CW-1:0]       r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic                r_flush, n_flush;
    logic [HEIGHT_W-1:0] r_left, n_left;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [CFG_W-1:0]    r_width;
    logic                r_byp_a, r_byp_b;
    logic [7:0]          r_byp_data;

    logic [HEIGHT_W-1:0] center, up, right;
    logic [XW-1:0]       cx, col_inc, wr, wx, rx, row_res;
    logic                last_col, has_left, has_right, has_up, has_down, ok;
    logic [SUM_W:0]      sum_raw;
    logic [SUM_W-1:0]    sum_sat;
    logic                cell_go, flush_go, emit;
    logic [CW-1:0]       raddr_b;

    // read data bypass for a write to the address read at the same edge
    assign center = r_byp_a ? r_byp_data[3:0] : i_ram_rdata_a[3:0];
    assign up     = r_byp_a ? r_byp_data[7:4] : i_ram_rdata_a[7:4];
    assign right  = r_byp_b ? r_byp_data[3:0] : i_ram_rdata_b[3:0];

    assign cx      = XW'(r_col);
    assign col_inc = cx + XW'(1);
    assign wr      = XW'(r_width);
    assign wx      = (r_width == '0) ? XW'(1) :
                     (wr > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : wr;
    assign last_col = (col_inc >= wx);
    assign rx       = XW'(r_row);
    assign row_res  = rx - XW'(1);

    assign has_left  = (r_col != '0);
    assign has_right = !last_col;
    assign has_up    = (rx >= XW'(2));
    assign has_down  = (i_action == ACT_CELL);

    assign ok = (!has_left  || (r_left   > center)) &&
                (!has_right || (right    > center)) &&
                (!has_up    || (up       > center)) &&
                (!has_down  || (i_height > center));

    assign sum_raw = {1'b0, r_sum} + (SUM_W+1)'(center) + (SUM_W+1)'(1);
    assign sum_sat = (sum_raw > {1'b0, SUM_MAX}) ? SUM_MAX : sum_raw[SUM_W-1:0];

    assign cell_go  = i_accept && (i_action == ACT_CELL) && !r_flush;
    assign flush_go = i_accept && (i_action == ACT_FLUSH) &&
                      (r_flush || ((r_col == '0) && (r_row != '0)));
    assign emit     = (cell_go && (r_row != '0)) || flush_go;

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_flush = r_flush;
        n_left  = r_left;
        n_sum   = r_sum;
        if (emit) begin
            n_left = center;
            if (ok) begin
                n_sum = sum_sat;
            end
        end
        if (cell_go) begin
            if (last_col) begin
                n_col = '0;
                if (r_row != RW'(MAX_ROWS - 1)) begin
                    n_row = r_row + RW'(1);
                end
            end else begin
                n_col = col_inc[CW-1:0];
            end
        end
        if (flush_go) begin
            n_flush = 1'b1;
            if (last_col) begin
                n_col   = '0;
                n_row   = '0;
                n_flush = 1'b0;
                n_left  = '0;
                n_sum   = '0;
            end else begin
                n_col = col_inc[CW-1:0];
            end
        end
    end

    assign raddr_b = (n_col == CW'(MAX_WIDTH - 1)) ? '0 : n_col + CW'(1);

    assign o_ram_we      = cell_go;
    assign o_ram_waddr   = r_col;
    assign o_ram_wdata   = {center, i_height};
    assign o_ram_raddr_a = n_col;
    assign o_ram_raddr_b = raddr_b;

    assign o_res_valid       = emit;
    assign o_res.is_minimum  = ok;
    assign o_res.cell_height = center;
    assign o_res.cell_column = (cx > XW'(FIELD7_MAX)) ? FIELD7_MAX : cx[FIELD7_W-1:0];
    assign o_res.cell_row    = (row_res > XW'(FIELD7_MAX)) ? FIELD7_MAX :
                               row_res[FIELD7_W-1:0];
    assign o_res.risk_sum    = ok ? sum_sat : r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_flush <= 1'b0;
            r_left  <= '0;
            r_sum   <= '0;
            r_width <= WIDTH_RST;
            r_byp_a <= 1'b0;
            r_byp_b <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_flush <= n_flush;
            r_left  <= n_left;
            r_sum   <= n_sum;
            if (i_cfg_we) begin
                r_width <= i_cfg_data;
            end
            r_byp_a <= cell_go && (n_col == r_col);
            r_byp_b <= cell_go && (raddr_b == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= {center, i_height};
    end

endmodule

// ----- hdl/glmd_outq.sv -----
// Two-entry result queue in front of the master port.
// Depends on glmd_pkg for the result type.
module glmd_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  glmd_pkg::t_result i_data,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output glmd_pkg::t_result o_data
);
    import glmd_pkg::*;

    t_result    r_q [2];
    logic [1:0] r_cnt;
    logic       pop;
    logic [1:0] wpos;

    assign pop     = (r_cnt != 2'd0) && i_ready;
    assign wpos    = r_cnt - {1'b0, pop};
    assign o_space = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && (wpos == 2'd0)) begin
            r_q[0] <= i_data;
        end else if (pop) begin
            r_q[0] <= r_q[1];
        end
        if (i_push && (wpos == 2'd1)) begin
            r_q[1] <= i_data;
        end
    end

endmodule

// ----- hdl/grid_local_minimum_detector_unit.sv -----
// Top level of the grid local minimum detector.
// Depends on glmd_pkg, glmd_ram, glmd_core and glmd_outq.
//
//  channel  dir  handshake                  payload
//  s        in   i_s_tvalid / o_s_tready    tuser: action, tdata: height
//  m        out  o_m_tvalid / i_m_tready    tuser: is_minimum, tdata: result
//  cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_data: row_width
//
// One beat per clock sustained while the result queue has space; each result is
// registered in the result queue before it leaves. The line store is a two-read-port
// RAM read one column ahead of the column being updated.
// Synchronous active-low reset; no clearing pass, the line store is unused until written.
// The two-entry result queue keeps o_s_tready high while one result waits.
module grid_local_minimum_detector_unit #(
    parameter int MAX_WIDTH = 128,
    parameter int MAX_ROWS  = 128
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [glmd_pkg::IN_TDATA_W-1:0]  i_s_tdata,  // [3:0] height
    input  logic                             i_s_tuser,  // [0] action
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [glmd_pkg::OUT_TDATA_W-1:0] o_m_tdata,  // cell_height, cell_column,
                                                         // cell_row, risk_sum
    output logic                             o_m_tuser,  // [0] is_minimum
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [glmd_pkg::CFG_W-1:0]       i_cfg_data
);
    import glmd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic          accept;
    logic          space;
    logic          res_valid;
    t_result       res;
    t_result       head;
    logic          ram_we;
    logic [CW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [7:0]    ram_wdata, ram_rdata_a, ram_rdata_b;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = space;
    assign accept      = i_s_tvalid && space;

    glmd_ram #(
        .W     (8),
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    glmd_core #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_action      (i_s_tuser),
        .i_height      (i_s_tdata[HEIGHT_W-1:0]),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_raddr_a (ram_raddr_a),
        .o_ram_raddr_b (ram_raddr_b),
        .i_ram_rdata_a (ram_rdata_a),
        .i_ram_rdata_b (ram_rdata_b)
    );

    glmd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_space (space),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (head)
    );

    assign o_m_tuser = head.is_minimum;
    assign o_m_tdata = {4'b0000, head.risk_sum, head.cell_row, head.cell_column,
                        head.cell_height};

endmodule

// ----- hdl/glmd_checker.sv -----
// Port-level checks of the grid local minimum detector, bound to the top level.
// Depends on glmd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module glmd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [glmd_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic                             o_m_tuser
);
    import glmd_pkg::*;

    `GLMD_ASSERT_ALWAYS(a_idle_after_reset, i_clk, !i_rst_n |=> !o_m_tvalid)

    `GLMD_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, !o_s_tready |-> o_m_tvalid)

    `GLMD_ASSERT(a_sum_covers_minimum, i_clk, i_rst_n, (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[35:18] > 18'(o_m_tdata[3:0])))

    `GLMD_ASSERT(a_result_held, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))

endmodule

bind grid_local_minimum_detector_unit glmd_checker u_glmd_checker (.*);
